// ===== sv/hbm_pkg.sv =====
// shared types, constants and popcount helpers for the hamming best-match unit
`default_nettype none

package hbm_pkg;

    localparam int DESC_WORDS = 4;
    localparam int INDEX_BITS = 12;
    localparam int IN_WORDS   = 4;
    localparam int USED_WORDS = (DESC_WORDS < IN_WORDS) ? DESC_WORDS : IN_WORDS;
    localparam int WSEL_W     = 2;
    localparam int CNT_W      = 2;
    localparam int DIST_W     = 9;
    localparam int Q_SHIFT    = 8;
    localparam int PROD_W     = 2 * DIST_W;

    localparam logic [DIST_W-1:0] NO_DISTANCE = DIST_W'(256);
    localparam logic [DIST_W-1:0] MAX_DIST_RST = DIST_W'(100);
    localparam logic [DIST_W-1:0] RATIO_RST    = DIST_W'(204);

    // input op codes
    localparam logic OP_QUERY = 1'b0;
    localparam logic OP_CAND  = 1'b1;

    // verdict codes
    localparam logic [1:0] ST_MATCH     = 2'd0;
    localparam logic [1:0] ST_NO_CAND   = 2'd1;
    localparam logic [1:0] ST_TOO_FAR   = 2'd2;
    localparam logic [1:0] ST_RATIO_BAD = 2'd3;

    // configuration register indexes
    localparam logic REG_MAX_DIST = 1'b0;
    localparam logic REG_RATIO    = 1'b1;

    localparam logic [31:0] M55 = 32'h5555_5555;
    localparam logic [31:0] M33 = 32'h3333_3333;
    localparam logic [31:0] M0F = 32'h0F0F_0F0F;

    typedef struct packed {
        logic        op;
        logic [63:0] desc_word0;
        logic [63:0] desc_word1;
        logic [63:0] desc_word2;
        logic [63:0] desc_word3;
        logic [1:0]  query_word_sel;
        logic [11:0] cand_index;
        logic        cand_valid;
        logic        last_candidate;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] match_index;
        logic [8:0]  match_distance;
        logic [8:0]  runner_up_distance;
    } t_out_word;

    typedef struct packed {
        logic             load_query;
        logic             capture;
        logic             acc_en;
        logic [CNT_W-1:0] word_sel;
        logic             update;
        logic             mult;
        logic             finish;
    } t_dp_cmd;

    typedef struct packed {
        logic item_op;
        logic item_valid;
        logic item_last;
        logic held_last;
    } t_dp_stat;

    function automatic logic [5:0] f_pop32(input logic [31:0] v);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        a = v - ((v >> 1) & M55);
        b = (a & M33) + ((a >> 2) & M33);
        c = (b + (b >> 4)) & M0F;
        return 6'(c[7:0] + c[15:8] + c[23:16] + c[31:24]);
    endfunction

    function automatic logic [6:0] f_pop64(input logic [63:0] v);
        return 7'(f_pop32(v[31:0])) + 7'(f_pop32(v[63:32]));
    endfunction

endpackage

`default_nettype wire

// ===== sv/hbm_ctrl.sv =====
// sequencer for query loads, per-word distance passes and the verdict
`default_nettype none

module hbm_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire hbm_pkg::t_dp_stat i_stat,
    output hbm_pkg::t_dp_cmd      o_cmd
);
    import hbm_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIST = 3'd1;
    localparam logic [2:0] S_UPD  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    localparam logic [CNT_W-1:0] LAST_WORD = CNT_W'(USED_WORDS - 1);

    logic [2:0]       r_state;
    logic [2:0]       n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.word_sel = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_stat.item_op == OP_QUERY) begin
                        o_cmd.load_query = 1'b1;
                    end else begin
                        o_cmd.capture = 1'b1;
                        n_cnt = '0;
                        if (i_stat.item_valid) begin
                            n_state = S_DIST;
                        end else if (i_stat.item_last) begin
                            n_state = S_MUL;
                        end
                    end
                end
            end
            S_DIST: begin
                o_cmd.acc_en = 1'b1;
                if (r_cnt == LAST_WORD) begin
                    n_state = S_UPD;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state = i_stat.held_last ? S_MUL : S_IDLE;
            end
            S_MUL: begin
                o_cmd.mult = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

// ===== sv/hbm_dp.sv =====
// query store, distance accumulator, best-two tracking and verdict register
`default_nettype none

module hbm_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire hbm_pkg::t_in_word             i_in,
    input  wire logic [hbm_pkg::DIST_W-1:0]    i_max_dist,
    input  wire logic [hbm_pkg::DIST_W-1:0]    i_ratio_q8,
    input  wire hbm_pkg::t_dp_cmd              i_cmd,
    output hbm_pkg::t_dp_stat                  o_stat,
    output hbm_pkg::t_out_word                 o_out,
    output logic                               o_done
);
    import hbm_pkg::*;

    logic [63:0]           r_query [IN_WORDS];
    logic [63:0]           r_cand  [IN_WORDS];
    logic [INDEX_BITS-1:0] r_idx;
    logic                  r_last;
    logic [DIST_W-1:0]     r_acc;
    logic [DIST_W-1:0]     r_best;
    logic [DIST_W-1:0]     r_second;
    logic [INDEX_BITS-1:0] r_best_idx;
    logic                  r_have;
    logic [PROD_W-1:0]     r_prod;
    t_out_word             r_out;
    logic                  r_done;

    logic [6:0]        pop;
    logic [PROD_W-1:0] best_q;
    logic [1:0]        verdict;

    assign pop = f_pop64(r_query[i_cmd.word_sel] ^ r_cand[i_cmd.word_sel]);
    assign best_q = PROD_W'({r_best, Q_SHIFT'(0)});

    always_comb begin
        if (!r_have) begin
            verdict = ST_NO_CAND;
        end else if (r_best > i_max_dist) begin
            verdict = ST_TOO_FAR;
        end else if (best_q >= r_prod) begin
            verdict = ST_RATIO_BAD;
        end else begin
            verdict = ST_MATCH;
        end
    end

    // query words, candidate words, product and verdict register, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_query && (32'(i_in.query_word_sel) < USED_WORDS)) begin
            r_query[i_in.query_word_sel] <= i_in.desc_word0;
        end
        if (i_cmd.capture) begin
            r_cand[0] <= i_in.desc_word0;
            r_cand[1] <= i_in.desc_word1;
            r_cand[2] <= i_in.desc_word2;
            r_cand[3] <= i_in.desc_word3;
            r_idx     <= INDEX_BITS'(i_in.cand_index);
        end
        if (i_cmd.mult) begin
            r_prod <= {DIST_W'(0), i_ratio_q8} * {DIST_W'(0), r_second};
        end
        if (i_cmd.finish) begin
            r_out.status             <= verdict;
            r_out.match_index        <= r_have ? 12'(r_best_idx) : 12'd0;
            r_out.match_distance     <= r_best;
            r_out.runner_up_distance <= r_second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last     <= 1'b0;
            r_acc      <= '0;
            r_best     <= NO_DISTANCE;
            r_second   <= NO_DISTANCE;
            r_best_idx <= '0;
            r_have     <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_done <= i_cmd.finish;
            if (i_cmd.capture) begin
                r_last <= i_in.last_candidate;
                r_acc  <= '0;
            end else if (i_cmd.acc_en) begin
                r_acc <= r_acc + DIST_W'(pop);
            end
            if (i_cmd.update) begin
                if (r_acc < r_best) begin
                    r_second   <= r_best;
                    r_best     <= r_acc;
                    r_best_idx <= r_idx;
                    r_have     <= 1'b1;
                end else if (r_acc < r_second) begin
                    r_second <= r_acc;
                end
            end else if (i_cmd.finish) begin
                r_best     <= NO_DISTANCE;
                r_second   <= NO_DISTANCE;
                r_best_idx <= '0;
                r_have     <= 1'b0;
            end
        end
    end

    assign o_stat.item_op    = i_in.op;
    assign o_stat.item_valid = i_in.cand_valid;
    assign o_stat.item_last  = i_in.last_candidate;
    assign o_stat.held_last  = r_last;
    assign o_out             = r_out;
    assign o_done            = r_done;

    a_best_le_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_best <= r_second)
        else $error("best distance above runner-up");

    a_empty_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_have |-> (r_best == NO_DISTANCE) && (r_second == NO_DISTANCE)
                    && (r_best_idx == '0))
        else $error("search state not clear without a best");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("verdict strobe held for two cycles");

endmodule

`default_nettype wire

// ===== sv/hamming_best_match_ratio_test_unit.sv =====
// top level: hamming nearest-neighbor search with ratio test and register port
//
//  channel   handshake                        payload
//  -------   ------------------------------   ---------------------------
//  input     start, busy (taken: start&!busy) i_in  (t_in_word)
//  result    o_done (one-cycle strobe)        o_out (t_out_word)
//  config    psel, penable, pwrite, pready    paddr, pwdata, prdata
//
// a query word load leaves busy low
// a candidate word is captured, then takes one 64-bit popcount
//   per cycle through the shared popcount unit, then the best-two update
// the word that closes a list adds the ratio multiply and verdict states; the
//   result strobe comes in the cycle after the verdict state, busy already low
// reset is synchronous, active low; it restores both registers and clears
//   the search state; query words hold garbage until loaded
// the receiver cannot stall: o_done is high for a single cycle; o_out holds the result until the next verdict
`default_nettype none

module hamming_best_match_ratio_test_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input word channel
    input  wire logic               start,
    output logic                    busy,
    input  wire hbm_pkg::t_in_word  i_in,
    // result channel
    output logic                    o_done,
    output hbm_pkg::t_out_word      o_out,
    // configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import hbm_pkg::*;

    // configuration registers
    logic [DIST_W-1:0] r_max_dist;
    logic [DIST_W-1:0] r_ratio_q8;
    logic              reg_sel;
    logic              cfg_wr;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    // write completes in the access phase
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_dist <= MAX_DIST_RST;
            r_ratio_q8 <= RATIO_RST;
        end else if (cfg_wr) begin
            case (reg_sel)
                REG_MAX_DIST: r_max_dist <= pwdata[DIST_W-1:0];
                REG_RATIO:    r_ratio_q8 <= pwdata[DIST_W-1:0];
                default:      ;
            endcase
        end
    end

    // read-back of the selected register
    always_comb begin
        case (reg_sel)
            REG_MAX_DIST: prdata = 32'(r_max_dist);
            REG_RATIO:    prdata = 32'(r_ratio_q8);
            default:      prdata = '0;
        endcase
    end

    // sequencer: accepts words, steps through descriptor words, closes lists
    hbm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // datapath: query store, popcount accumulate, best-two, verdict
    hbm_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_max_dist (r_max_dist),
        .i_ratio_q8 (r_ratio_q8),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_out      (o_out),
        .o_done     (o_done)
    );

endmodule

`default_nettype wire
